>>> design/tfpc_pkg.sv
// Package for the tank fill pump controller: types, codes and step helpers.
package tfpc_pkg;

  localparam int NUM_CH    = 3;   // channel fields are three bits wide
  localparam int CHANNELS  = 3;   // channels wired to sensors and valves
  localparam int TIME_W    = 32;
  localparam int DUR_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int IN_W      = 80;
  localparam int OUT_W     = 16;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PREOPEN = 2'd1;
  localparam logic [1:0] PH_FILLING = 2'd2;
  localparam logic [1:0] NONE_CH    = 2'd3;

  localparam logic [3:0] AL_NO_FLOW  = 4'b0001;
  localparam logic [3:0] AL_LEVEL    = 4'b0010;
  localparam logic [3:0] AL_TIMEOUT  = 4'b0100;
  localparam logic [3:0] AL_CLOCK    = 4'b1000;
  localparam logic [3:0] AL_BLOCKING = AL_NO_FLOW | AL_LEVEL;

  localparam logic [CFG_IDX_W-1:0] REG_MASK      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILL1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILL2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREOPEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_START = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_GAP  = 3'd7;

  localparam logic [NUM_CH-1:0] RST_MASK       = 3'd7;
  localparam logic [TIME_W-1:0] RST_FILL_LIMIT = 32'd600000;
  localparam logic [DUR_W-1:0]  RST_PREOPEN    = 16'd2000;
  localparam logic [DUR_W-1:0]  RST_OFF_DELAY  = 16'd2000;
  localparam logic [DUR_W-1:0]  RST_FLOW_START = 16'd10000;
  localparam logic [DUR_W-1:0]  RST_FLOW_GAP   = 16'd5000;

  typedef struct packed {
    logic [1:0]        phase;
    logic [1:0]        active;
    logic              cs_vld;
    logic [TIME_W-1:0] cs_t;
    logic              ps_vld;
    logic [TIME_W-1:0] ps_t;
    logic              sr_vld;
    logic [TIME_W-1:0] sr_t;
    logic [3:0]        alarm;
    logic              pump;
    logic [NUM_CH-1:0] valve;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_IDLE, active: NONE_CH, cs_vld: 1'b0, cs_t: '0, ps_vld: 1'b0, ps_t: '0,
    sr_vld: 1'b0, sr_t: '0, alarm: 4'd0, pump: 1'b0, valve: '0};

  // elapsed time since a valid stamp has reached dur (modular)
  function automatic logic passed(input logic vld, input logic [TIME_W-1:0] t,
                                  input logic [TIME_W-1:0] now,
                                  input logic [TIME_W-1:0] dur);
    logic [TIME_W-1:0] el;
    el = now - t;
    return vld && (el >= dur);
  endfunction

  function automatic state_t safe_stop(input state_t s, input logic [3:0] al);
    state_t r;
    r        = STATE_RESET;
    r.alarm  = s.alarm | al;
    return r;
  endfunction

  function automatic state_t end_cycle(input state_t s, input logic [TIME_W-1:0] now);
    state_t r;
    r = s;
    if (s.active != NONE_CH) r.valve[s.active] = 1'b0;
    r.phase  = PH_IDLE;
    r.active = NONE_CH;
    r.cs_vld = 1'b0;
    r.cs_t   = '0;
    r.sr_vld = 1'b1;
    r.sr_t   = now;
    return r;
  endfunction

endpackage

>>> design/tank_fill_pump_controller.sv
// Top level of the tank fill pump controller.
//
// One input transfer on s_* is one control tick: time, manual and pump-request
// switches, per-channel low/high level sensors and the latest flow pulse time.
// Each tick yields exactly one result transfer on m_*: valve mask, pump drive,
// sticky alarms, cycle phase and active channel, all as state after the tick.
// Configuration goes in through cfg_wr_en/cfg_index/cfg_wdata, one register
// per cycle, and is meant to change only while no tick is in flight.
//
// Datapath: an input register, then one pass of step logic (a handful of
// 32-bit subtract/compares per channel plus the pump and flow checks) that
// updates the controller state and loads the result register together.
// Throughput: one tick per cycle unless m_tready holds the result register.
// When m_tready is low the result register holds; the input register still
// takes one more tick, then s_tready drops until the result moves on.
// Synchronous reset restores default configuration, idle phase, no channel,
// valves closed, pump off, alarms clear and both stages empty.
module tank_fill_pump_controller (
  input  logic                            clk,
  input  logic                            rst,
  // config write port
  input  logic                            cfg_wr_en,
  input  logic [tfpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfpc_pkg::CFG_W-1:0]      cfg_wdata,
  // tick input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // now_ms[31:0], manual_switch[32], pump_request[33], level_low_bits[36:34],
  // level_high_bits[39:37], last_pulse_ms[71:40], pulse_seen[72], zero pad
  input  logic [tfpc_pkg::IN_W-1:0]       s_tdata,
  // result output
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // valve_bits[2:0], pump_on[3], alarm_bits[7:4], cycle_phase[9:8],
  // active_index[11:10], zero pad
  output logic [tfpc_pkg::OUT_W-1:0]      m_tdata
);
  import tfpc_pkg::*;

  // configuration
  logic [NUM_CH-1:0] tank_mask;
  logic [TIME_W-1:0] fill_limit [NUM_CH];
  logic [DUR_W-1:0]  preopen;
  logic [DUR_W-1:0]  off_delay;
  logic [DUR_W-1:0]  flow_start;
  logic [DUR_W-1:0]  flow_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      tank_mask  <= RST_MASK;
      for (int i = 0; i < NUM_CH; i++) fill_limit[i] <= RST_FILL_LIMIT;
      preopen    <= RST_PREOPEN;
      off_delay  <= RST_OFF_DELAY;
      flow_start <= RST_FLOW_START;
      flow_gap   <= RST_FLOW_GAP;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MASK:       tank_mask     <= cfg_wdata[NUM_CH-1:0];
        REG_FILL0:      fill_limit[0] <= cfg_wdata[TIME_W-1:0];
        REG_FILL1:      fill_limit[1] <= cfg_wdata[TIME_W-1:0];
        REG_FILL2:      fill_limit[2] <= cfg_wdata[TIME_W-1:0];
        REG_PREOPEN:    preopen       <= cfg_wdata[DUR_W-1:0];
        REG_OFF_DELAY:  off_delay     <= cfg_wdata[DUR_W-1:0];
        REG_FLOW_START: flow_start    <= cfg_wdata[DUR_W-1:0];
        REG_FLOW_GAP:   flow_gap      <= cfg_wdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // channel enable: mask bit and a channel that exists
  logic [NUM_CH-1:0] chan_en;
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) chan_en[ch] = tank_mask[ch] && (ch < CHANNELS);
  end

  // pipeline handshake
  logic             in_vld;
  logic [IN_W-1:0]  in_data;
  logic             advance;

  assign advance  = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) in_vld <= 1'b0;
    else if (s_tready) in_vld <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_data <= s_tdata;
  end

  // unpack the registered tick
  logic [TIME_W-1:0] now;
  logic              manual;
  logic              request;
  logic [NUM_CH-1:0] lows;
  logic [NUM_CH-1:0] highs;
  logic [TIME_W-1:0] last_pulse;
  logic              seen;

  assign now        = in_data[31:0];
  assign manual     = in_data[32];
  assign request    = in_data[33];
  assign lows       = in_data[36:34];
  assign highs      = in_data[39:37];
  assign last_pulse = in_data[71:40];
  assign seen       = in_data[72];

  // controller state and step logic
  state_t st, st_next;

  always_comb begin
    state_t            n;
    logic              done;
    logic              started;
    logic [TIME_W-1:0] ref_t;
    logic [TIME_W-1:0] lim;
    logic [TIME_W-1:0] elapsed;
    n = st;
    done = 1'b0;
    started = 1'b0;
    ref_t = '0;
    lim = '0;
    elapsed = '0;

    // manual mode finishes a running cycle
    if (manual && n.phase != PH_IDLE) n = end_cycle(n, now);
    n.alarm = n.alarm | AL_CLOCK;

    if (!manual) begin
      // supervise the active channel, flag inconsistent sensors
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (!done && chan_en[ch]) begin
          if (lows[ch] && highs[ch]) begin
            if (n.active == 2'(ch)) n = safe_stop(n, AL_LEVEL);
            else begin
              n.valve[ch] = 1'b0;
              n.alarm     = n.alarm | AL_LEVEL;
            end
          end else if (n.active == 2'(ch) && n.phase == PH_FILLING) begin
            if (highs[ch]) n = end_cycle(n, now);
            else if (passed(n.cs_vld, n.cs_t, now, fill_limit[ch]))
              n = safe_stop(n, AL_TIMEOUT);
            done = 1'b1;
          end
        end
      end
      // start a new cycle on the first channel that needs water
      if (!done && n.phase == PH_IDLE && (n.alarm & AL_BLOCKING) == 4'd0) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (!started && chan_en[ch] && lows[ch] && !highs[ch]) begin
            n.valve[ch] = 1'b1;
            n.active    = 2'(ch);
            n.cs_vld    = 1'b1;
            n.cs_t      = now;
            n.phase     = PH_PREOPEN;
            started     = 1'b1;
          end
        end
      end
    end

    if (n.phase == PH_PREOPEN && passed(n.cs_vld, n.cs_t, now, TIME_W'(preopen)))
      n.phase = PH_FILLING;

    // pump drive with off delay
    if (n.phase == PH_FILLING || (request && (n.alarm & AL_BLOCKING) == 4'd0)) begin
      n.pump = 1'b1;
      if (!n.ps_vld) begin
        n.ps_vld = 1'b1;
        n.ps_t   = now;
      end
    end else if (passed(n.sr_vld, n.sr_t, now, TIME_W'(off_delay))) begin
      n.pump   = 1'b0;
      n.ps_vld = 1'b0;
      n.ps_t   = '0;
    end

    // loss of flow
    if (n.pump && n.ps_vld) begin
      ref_t   = seen ? last_pulse : n.ps_t;
      lim     = seen ? TIME_W'(flow_gap) : TIME_W'(flow_start);
      elapsed = now - ref_t;
      if (elapsed > lim) n = safe_stop(n, AL_NO_FLOW);
    end

    st_next = n;
  end

  always_ff @(posedge clk) begin
    if (rst) st <= STATE_RESET;
    else if (advance) st <= st_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (!m_tvalid || m_tready) m_tvalid <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (advance)
      m_tdata <= {4'd0, st_next.active, st_next.phase, st_next.alarm,
                  st_next.pump, st_next.valve};
  end

  // checks
  a_idle_none: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_IDLE) == (st.active == NONE_CH))
    else $error("phase and active channel disagree");

  a_valve_idle: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_IDLE) |-> (st.valve == '0))
    else $error("valve open while idle");

  a_valve_active: assert property (@(posedge clk) disable iff (rst)
    (st.phase != PH_IDLE) |-> (st.valve == (NUM_CH'(1) << st.active)))
    else $error("valve mask does not match active channel");

  a_fill_pump: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_FILLING) |-> st.pump)
    else $error("filling without pump");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !advance) |=> (in_vld && $stable(in_data)))
    else $error("stalled tick lost");

  a_clock_alarm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7])
    else $error("clock alarm missing in result");

endmodule

>>> bench/tb.sv
// Self-checking bench for the tank fill pump controller: driver, monitor, predictor.
`timescale 1ns / 1ps

module tb;
  import tfpc_pkg::*;

  // ---------------------------------------------------------------------------
  // Tick and outcome records, as they travel on s_tdata / m_tdata
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [TIME_W-1:0] now;
    logic              manual;
    logic              req;
    logic [NUM_CH-1:0] lows;
    logic [NUM_CH-1:0] highs;
    logic [TIME_W-1:0] last;
    logic              seen;
  } tick_t;

  typedef struct {
    logic [NUM_CH-1:0] valve;
    logic              pump;
    logic [3:0]        alarm;
    logic [1:0]        phase;
    logic [1:0]        active;
  } outcome_t;

  // Back-pressure / gap profiles applied per stimulus phase
  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int WATCHDOG_LIMIT = 5000;

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  // now_ms, manual_switch, pump_request, level_low_bits, level_high_bits,
  // last_pulse_ms, pulse_seen, zero pad (lowest bit up)
  logic [IN_W-1:0]      s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  // valve_bits, pump_on, alarm_bits, cycle_phase, active_index, zero pad
  logic [OUT_W-1:0]     m_tdata;

  tank_fill_pump_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the configuration and controller state
  // ---------------------------------------------------------------------------
  logic [NUM_CH-1:0] c_mask     = RST_MASK;
  logic [TIME_W-1:0] c_fill [0:2] = '{RST_FILL_LIMIT, RST_FILL_LIMIT, RST_FILL_LIMIT};
  logic [DUR_W-1:0]  c_preopen  = RST_PREOPEN;
  logic [DUR_W-1:0]  c_offdly   = RST_OFF_DELAY;
  logic [DUR_W-1:0]  c_fstart   = RST_FLOW_START;
  logic [DUR_W-1:0]  c_fgap     = RST_FLOW_GAP;

  logic [1:0]        ctl_phase  = PH_IDLE;
  logic [1:0]        ctl_chan   = NONE_CH;
  logic              fill_ok    = 1'b0;   // cycle start stamp
  logic [TIME_W-1:0] fill_t0    = '0;
  logic              pump_ok    = 1'b0;   // pump start stamp
  logic [TIME_W-1:0] pump_t0    = '0;
  logic              stop_ok    = 1'b0;   // stop request stamp
  logic [TIME_W-1:0] stop_t0    = '0;
  logic [3:0]        ctl_alarm  = '0;
  logic              ctl_pump   = 1'b0;
  logic [NUM_CH-1:0] ctl_valve  = '0;

  // modular elapsed time of a valid stamp has reached dur
  function automatic logic stamp_reached(input logic ok, input logic [TIME_W-1:0] t0,
                                         input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] dur);
    logic [TIME_W-1:0] el;
    el = now - t0;
    return ok && (el >= dur);
  endfunction

  // safety stop: everything off and forgotten, alarm latched
  function automatic void halt_all(input logic [3:0] al);
    ctl_valve = '0;
    ctl_pump  = 1'b0;
    ctl_phase = PH_IDLE;
    ctl_chan  = NONE_CH;
    fill_ok   = 1'b0;
    fill_t0   = '0;
    pump_ok   = 1'b0;
    pump_t0   = '0;
    stop_ok   = 1'b0;
    stop_t0   = '0;
    ctl_alarm = ctl_alarm | al;
  endfunction

  // normal cycle end: close the active valve and start the pump off delay
  function automatic void close_cycle(input logic [TIME_W-1:0] now);
    if (ctl_chan != NONE_CH) ctl_valve[ctl_chan] = 1'b0;
    ctl_phase = PH_IDLE;
    ctl_chan  = NONE_CH;
    fill_ok   = 1'b0;
    fill_t0   = '0;
    stop_ok   = 1'b1;
    stop_t0   = now;
  endfunction

  function automatic void scan_channels(input logic [TIME_W-1:0] now,
                                        input logic [NUM_CH-1:0] lows,
                                        input logic [NUM_CH-1:0] highs);
    bit done;
    done = 0;
    for (int ch = 0; ch < CHANNELS && !done; ch++) begin
      if (c_mask[ch]) begin
        if (lows[ch] && highs[ch]) begin
          // both sensors on: stop if it is ours, else just shut that valve
          if (ctl_chan == ch) begin
            halt_all(AL_LEVEL);
          end else begin
            ctl_valve[ch] = 1'b0;
            ctl_alarm     = ctl_alarm | AL_LEVEL;
          end
        end else if (ctl_chan == ch && ctl_phase == PH_FILLING) begin
          if (highs[ch]) close_cycle(now);
          else if (stamp_reached(fill_ok, fill_t0, now, c_fill[ch])) halt_all(AL_TIMEOUT);
          done = 1;
        end
      end
    end
    if (done || ctl_phase != PH_IDLE || (ctl_alarm & AL_BLOCKING) != 0) return;
    // start a new cycle on the first enabled channel asking for water
    for (int ch = 0; ch < CHANNELS && !done; ch++) begin
      if (c_mask[ch] && lows[ch] && !highs[ch]) begin
        ctl_valve[ch] = 1'b1;
        ctl_chan      = 2'(ch);
        fill_ok       = 1'b1;
        fill_t0       = now;
        ctl_phase     = PH_PREOPEN;
        done          = 1;
      end
    end
  endfunction

  // one control tick through the predictor; returns the state after the tick
  function automatic outcome_t step_controller(input tick_t t);
    outcome_t          o;
    logic [TIME_W-1:0] flow_ref;
    logic [TIME_W-1:0] el;
    logic [TIME_W-1:0] lim;
    if (t.manual && ctl_phase != PH_IDLE) close_cycle(t.now);
    ctl_alarm = ctl_alarm | AL_CLOCK;
    if (!t.manual) scan_channels(t.now, t.lows, t.highs);
    if (ctl_phase == PH_PREOPEN &&
        stamp_reached(fill_ok, fill_t0, t.now, TIME_W'(c_preopen)))
      ctl_phase = PH_FILLING;

    if (ctl_phase == PH_FILLING || (t.req && (ctl_alarm & AL_BLOCKING) == 0)) begin
      ctl_pump = 1'b1;
      if (!pump_ok) begin
        pump_ok = 1'b1;
        pump_t0 = t.now;
      end
    end else if (stamp_reached(stop_ok, stop_t0, t.now, TIME_W'(c_offdly))) begin
      ctl_pump = 1'b0;
      pump_ok  = 1'b0;
      pump_t0  = '0;
    end

    // flow supervision: gap since last pulse, or since pump start if none yet
    if (ctl_pump && pump_ok) begin
      flow_ref = t.seen ? t.last : pump_t0;
      lim      = t.seen ? TIME_W'(c_fgap) : TIME_W'(c_fstart);
      el       = t.now - flow_ref;
      if (el > lim) halt_all(AL_NO_FLOW);
    end

    o.valve  = ctl_valve;
    o.pump   = ctl_pump;
    o.alarm  = ctl_alarm;
    o.phase  = ctl_phase;
    o.active = ctl_chan;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, counters and per-phase knobs
  // ---------------------------------------------------------------------------
  tick_t      tick_q[$];      // ticks waiting to be driven
  outcome_t   outcome_q[$];   // predicted outcomes of accepted ticks, oldest first
  tick_t      cur_tick;       // tick currently on s_tdata
  idle_mode_t idle_mode = IDLE_NONE;
  int         err_cnt   = 0;
  int         quiet_cnt = 0;

  // stimulus generator state: running clock and per-channel level pattern
  logic [TIME_W-1:0] sim_now = '0;
  logic [NUM_CH-1:0] lvl_lo  = '0;
  logic [NUM_CH-1:0] lvl_hi  = '0;

  // ---------------------------------------------------------------------------
  // Driver: presents ticks from tick_q, predicts each one at its transfer edge.
  // s_tvalid/s_tdata get a single NBA per edge, and are held while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit gap_draw;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) outcome_q.push_back(step_controller(cur_tick));
      if (!s_tvalid || s_tready) begin
        gap_draw = (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 63) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 8);
        if (tick_q.size() != 0 && !gap_draw) begin
          cur_tick = tick_q.pop_front();
          s_tdata  <= {7'd0, cur_tick.seen, cur_tick.last, cur_tick.highs, cur_tick.lows,
                       cur_tick.req, cur_tick.manual, cur_tick.now};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.valve  = m_tdata[2:0];
        got.pump   = m_tdata[3];
        got.alarm  = m_tdata[7:4];
        got.phase  = m_tdata[9:8];
        got.active = m_tdata[11:10];
        if (outcome_q.size() == 0) begin
          $error("result transfer with no tick outstanding: 0x%0h", m_tdata);
          err_cnt++;
        end else begin
          want = outcome_q.pop_front();
          check_field("valve_bits",   32'(want.valve),  32'(got.valve));
          check_field("pump_on",      32'(want.pump),   32'(got.pump));
          check_field("alarm_bits",   32'(want.alarm),  32'(got.alarm));
          check_field("cycle_phase",  32'(want.phase),  32'(got.phase));
          check_field("active_index", 32'(want.active), 32'(got.active));
        end
      end
      m_tready <= !((idle_mode == IDLE_RECV && $urandom_range(0, 99) < 63) ||
                    (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 8));
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too many cycles in a row with no transfer on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_tick(input logic [TIME_W-1:0] now, input logic manual,
                           input logic req, input logic [NUM_CH-1:0] lows,
                           input logic [NUM_CH-1:0] highs,
                           input logic [TIME_W-1:0] last, input logic seen);
    tick_t t;
    t.now    = now;
    t.manual = manual;
    t.req    = req;
    t.lows   = lows;
    t.highs  = highs;
    t.last   = last;
    t.seen   = seen;
    tick_q.push_back(t);
  endtask

  // wait until no tick is queued, on the bus or in flight, then cover latency
  task automatic settle();
    while (tick_q.size() != 0 || s_tvalid || outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write; the predictor copy follows at once (block is idle)
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MASK:       c_mask    = val[NUM_CH-1:0];
      REG_FILL0:      c_fill[0] = val;
      REG_FILL1:      c_fill[1] = val;
      REG_FILL2:      c_fill[2] = val;
      REG_PREOPEN:    c_preopen = val[DUR_W-1:0];
      REG_OFF_DELAY:  c_offdly  = val[DUR_W-1:0];
      REG_FLOW_START: c_fstart  = val[DUR_W-1:0];
      REG_FLOW_GAP:   c_fgap    = val[DUR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [NUM_CH-1:0] mask,
                              input logic [TIME_W-1:0] f0, input logic [TIME_W-1:0] f1,
                              input logic [TIME_W-1:0] f2, input logic [DUR_W-1:0] pre,
                              input logic [DUR_W-1:0] off, input logic [DUR_W-1:0] fs,
                              input logic [DUR_W-1:0] fg);
    write_reg(REG_MASK,       CFG_W'(mask));
    write_reg(REG_FILL0,      f0);
    write_reg(REG_FILL1,      f1);
    write_reg(REG_FILL2,      f2);
    write_reg(REG_PREOPEN,    CFG_W'(pre));
    write_reg(REG_OFF_DELAY,  CFG_W'(off));
    write_reg(REG_FLOW_START, CFG_W'(fs));
    write_reg(REG_FLOW_GAP,   CFG_W'(fg));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random ticks. Clean mode keeps flow pulses fresh and enabled channels
  // consistent, so the sticky blocking alarms stay clear and fill cycles keep
  // running; noisy mode lets sensors and pulse times go bad.
  task automatic gen_ticks(input int count, input bit noisy, input int step_max);
    int r;
    tick_t t;
    for (int i = 0; i < count; i++) begin
      sim_now = sim_now + $urandom_range(0, step_max);
      // levels drift slowly so fills can run into preopen, high level or timeout
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if ($urandom_range(0, 99) < 30) begin
          r = $urandom_range(0, 3);
          lvl_lo[ch] = (r <= 1);
          lvl_hi[ch] = (r == 3);
          if ((!c_mask[ch] && $urandom_range(0, 3) == 0) ||
              (noisy && $urandom_range(0, 19) == 0)) begin
            lvl_lo[ch] = 1'b1;
            lvl_hi[ch] = 1'b1;
          end
        end
      end
      t.now    = sim_now;
      t.manual = ($urandom_range(0, 99) < 5);
      t.req    = ($urandom_range(0, 99) < 20);
      t.lows   = lvl_lo;
      t.highs  = lvl_hi;
      if (!noisy) begin
        t.seen = 1'b1;
        t.last = sim_now - $urandom_range(0, c_fgap);
      end else begin
        t.seen = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0:       t.last = $urandom;
          1:       t.last = sim_now + $urandom_range(1, 1000);   // pulse in the future
          default: t.last = sim_now - $urandom_range(0, c_fgap);
        endcase
      end
      tick_q.push_back(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [TIME_W-1:0] n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset configuration: idle tick, independent pump, a full fill
    // ended by high level, manual abort of preopen, off delay, fill timeout,
    // then time wrapping through zero.
    idle_mode = IDLE_NONE;
    push_tick(32'd0,      0, 0, 3'b000, 3'b000, 32'd0,        0);
    push_tick(32'd0,      0, 1, 3'b000, 3'b000, 32'd0,        0);
    push_tick(32'd100,    0, 0, 3'b000, 3'b000, 32'hFFFFFFFF, 1);
    push_tick(32'd200,    0, 0, 3'b001, 3'b000, 32'd150,      1);
    push_tick(32'd2200,   0, 0, 3'b001, 3'b000, 32'd2200,     1);
    push_tick(32'd2300,   0, 0, 3'b001, 3'b100, 32'd2250,     1);
    push_tick(32'd3000,   0, 0, 3'b000, 3'b001, 32'd2900,     1);
    push_tick(32'd4000,   0, 0, 3'b010, 3'b001, 32'd3900,     1);
    push_tick(32'd4500,   1, 0, 3'b010, 3'b000, 32'd4400,     1);
    push_tick(32'd6500,   1, 0, 3'b111, 3'b000, 32'd6400,     1);
    push_tick(32'd6600,   0, 0, 3'b111, 3'b000, 32'd6500,     1);
    push_tick(32'd8600,   0, 0, 3'b111, 3'b000, 32'd8600,     1);
    push_tick(32'd608600, 0, 0, 3'b111, 3'b000, 32'd608600,   1);
    push_tick(32'hFFFFFFF0, 0, 1, 3'b000, 3'b000, 32'hFFFFFFF0, 1);
    push_tick(32'hFFFFFFFF, 1, 1, 3'b111, 3'b000, 32'hFFFFFFFF, 1);
    push_tick(32'd0,      0, 0, 3'b100, 3'b011, 32'd0,        1);
    push_tick(32'd10,     0, 0, 3'b100, 3'b000, 32'd5,        1);
    settle();

    // Random phases, each after a fresh register set written while idle.
    // Each drain between phases also makes the sender wait for every result.
    program_regs(3'd7, 32'd3000, 32'd5000, 32'd8000, 16'd500, 16'd1000, 16'd2000, 16'd1000);
    sim_now   = $urandom;
    idle_mode = IDLE_NONE;
    gen_ticks(330, 0, 400);
    settle();

    // lower extremes: zero delays and flow limits, small fill limits, channel 1 disabled
    program_regs(3'd5, 32'd0, 32'd1, 32'd100, 16'd0, 16'd0, 16'd0, 16'd0);
    idle_mode = IDLE_SEND;
    gen_ticks(330, 0, 50);
    settle();

    // upper extremes, clock about to wrap, channel 2 disabled
    program_regs(3'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    sim_now   = 32'hFFF00000;
    idle_mode = IDLE_RECV;
    gen_ticks(330, 0, 20000);
    settle();

    program_regs(3'($urandom_range(1, 7)), $urandom_range(0, 20000), $urandom_range(0, 20000),
                 $urandom_range(0, 20000), 16'($urandom_range(0, 3000)),
                 16'($urandom_range(0, 3000)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
    sim_now   = $urandom;
    idle_mode = IDLE_BOTH;
    gen_ticks(330, 0, $urandom_range(10, 2000));
    settle();

    // no channel enabled: levels of any shape are ignored
    program_regs(3'd0, $urandom, $urandom, $urandom, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'd60000, 16'd60000);
    idle_mode = IDLE_NONE;
    gen_ticks(40, 0, 300);
    settle();

    // Last phase: the blocking alarms never clear, so they come at the end.
    // Inconsistent level on another channel while filling, then on the active
    // one (safety stop), then a blocked pump request with a future pulse.
    program_regs(3'd7, 32'd4000, 32'd4000, 32'd4000, 16'd1000, 16'd1500, 16'd8000, 16'd3000);
    idle_mode = IDLE_RECV;
    n = sim_now + 32'd10;
    push_tick(n,            1, 0, 3'b000, 3'b000, n,            1);
    push_tick(n + 32'd1,    0, 0, 3'b001, 3'b000, n,            1);
    push_tick(n + 32'd1001, 0, 0, 3'b001, 3'b000, n + 32'd1001, 1);
    push_tick(n + 32'd1100, 0, 0, 3'b011, 3'b010, n + 32'd1050, 1);
    push_tick(n + 32'd1200, 0, 0, 3'b001, 3'b001, n + 32'd1150, 1);
    push_tick(n + 32'd1300, 0, 1, 3'b000, 3'b000, n + 32'd2000, 1);
    sim_now = n + 32'd1300;
    gen_ticks(300, 1, 500);
    settle();

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
design/tfpc_pkg.sv
design/tank_fill_pump_controller.sv
bench/tb.sv
